@@ rtl/expression_token_lexer_top_defines.svh @@
// Assertion macros for the expression token lexer.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef EXPRESSION_TOKEN_LEXER_TOP_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset
`define ETL_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ETL_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ETL_ASSERT_ALWAYS(name, cond, msg)
`define ETL_ASSERT_IMPLY(name, ante, cons, msg)

`endif

`endif

@@ rtl/etl_pkg.sv @@
package etl_pkg;

  // Token kinds as seen on the result channel
  typedef enum logic [4:0] {
    K_IDENT  = 5'd0,
    K_NUMBER = 5'd1,
    K_PLUS   = 5'd2,
    K_MINUS  = 5'd3,
    K_MUL    = 5'd4,
    K_DIV    = 5'd5,
    K_LPAREN = 5'd6,
    K_RPAREN = 5'd7,
    K_QUOTE  = 5'd8,
    K_LBRACE = 5'd9,
    K_RBRACE = 5'd10,
    K_LT     = 5'd11,
    K_LE     = 5'd12,
    K_GT     = 5'd13,
    K_GE     = 5'd14,
    K_NE     = 5'd15,
    K_ASSIGN = 5'd16,
    K_EQ     = 5'd17,
    K_STRING = 5'd18,
    K_OTHER  = 5'd19,
    K_END    = 5'd20
  } kind_e;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    logic        cv;
    logic        te;
  } result_t;

  // Work handed from the front to the back: up to two classifications and END
  typedef struct packed {
    logic       a_valid;
    logic [7:0] a_char;
    logic [7:0] a_next;
    logic       b_valid;
    logic [7:0] b_char;
    logic       last;
  } job_t;

  // Outcome of classifying one kept byte
  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
    logic       skip_n;
    logic       inq_n;
  } cls_t;

  function automatic result_t mk_char(input kind_e k, input logic [7:0] c, input logic e);
    result_t r;
    r.kind = k;
    r.ch   = c;
    r.cv   = 1'b1;
    r.te   = e;
    return r;
  endfunction

  function automatic result_t mk_empty(input kind_e k);
    result_t r;
    r.kind = k;
    r.ch   = CH_NUL;
    r.cv   = 1'b0;
    r.te   = 1'b1;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Classify kept byte c against lookahead nx given the current skip and quote state
  function automatic cls_t classify(input logic [7:0] c, input logic [7:0] nx,
                                    input logic skip, input logic inq);
    cls_t  r;
    logic  q;
    logic  pair;
    kind_e k1;
    kind_e k2;
    r        = '0;
    r.inq_n  = inq;
    r.skip_n = 1'b0;
    q        = inq ^ (c == CH_QUOTE);
    pair     = (nx == CH_EQ);
    k1       = K_EQ;
    k2       = K_ASSIGN;
    if (!skip) begin
      r.inq_n = q;
      if (q) begin
        if (c == CH_QUOTE) begin
          r.res0 = mk_char(K_QUOTE, c, 1'b1);
          r.res1 = mk_empty(K_STRING);
          r.cnt  = (nx == CH_QUOTE) ? 2'd2 : 2'd1;
        end else begin
          r.res0 = mk_char(K_STRING, c, nx == CH_QUOTE);
          r.cnt  = 2'd1;
        end
      end else if (is_letter(c)) begin
        r.res0 = mk_char(K_IDENT, c, !is_letter(nx));
        r.cnt  = 2'd1;
      end else if (is_digit(c)) begin
        r.res0 = mk_char(K_NUMBER, c, !is_digit(nx));
        r.cnt  = 2'd1;
      end else begin
        r.cnt  = 2'd1;
        r.res0 = mk_empty(K_OTHER);
        case (c)
          CH_PLUS:   r.res0 = mk_char(K_PLUS, c, 1'b1);
          CH_MINUS:  r.res0 = mk_char(K_MINUS, c, 1'b1);
          CH_STAR:   r.res0 = mk_char(K_MUL, c, 1'b1);
          CH_SLASH:  r.res0 = mk_char(K_DIV, c, 1'b1);
          CH_LPAREN: r.res0 = mk_char(K_LPAREN, c, 1'b1);
          CH_RPAREN: r.res0 = mk_char(K_RPAREN, c, 1'b1);
          CH_QUOTE:  r.res0 = mk_char(K_QUOTE, c, 1'b1);
          CH_LBRACE: r.res0 = mk_char(K_LBRACE, c, 1'b1);
          CH_RBRACE: r.res0 = mk_char(K_RBRACE, c, 1'b1);
          CH_LT, CH_GT, CH_BANG, CH_EQ: begin
            case (c)
              CH_LT:   begin k1 = K_LE; k2 = K_LT;     end
              CH_GT:   begin k1 = K_GE; k2 = K_GT;     end
              CH_BANG: begin k1 = K_NE; k2 = K_OTHER;  end
              default: begin k1 = K_EQ; k2 = K_ASSIGN; end
            endcase
            if (pair) begin
              r.res0   = mk_char(k1, c, 1'b0);
              r.res1   = mk_char(k1, CH_EQ, 1'b1);
              r.cnt    = 2'd2;
              r.skip_n = 1'b1;
            end else begin
              r.res0 = mk_char(k2, c, 1'b1);
            end
          end
          default: r.res0 = mk_empty(K_OTHER);
        endcase
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/etl_if.sv @@
// Source byte channel
interface etl_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// Token result channel
interface etl_tok_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] text_char;
  logic       char_valid;
  logic       token_end;

  modport source (output valid, output token_kind, output text_char, output char_valid,
                  output token_end, input ready);
  modport sink   (input valid, input token_kind, input text_char, input char_valid,
                  input token_end, output ready);
endinterface

@@ rtl/etl_front.sv @@
module etl_front (
  input  logic          clk,
  input  logic          rst,
  etl_src_if.sink       src,
  input  logic          push_ready,
  output logic          push_valid,
  output etl_pkg::job_t push_data
);
  import etl_pkg::*;

  logic [7:0] pending_char;
  logic       pending_valid;
  logic       filter_in_quotes;

  logic       accept;
  logic       quote_next;
  logic       keep;

  assign src.ready = push_ready;
  assign accept    = src.valid && src.ready;

  // Track quote parity and drop blanks outside strings
  always_comb begin
    quote_next = filter_in_quotes ^ (src.in_char == CH_QUOTE);
    keep       = quote_next || (src.in_char != CH_SPACE && src.in_char != CH_NL);
  end

  // Pair the held byte with its lookahead; on the final byte add the flush and END
  always_comb begin
    push_data.a_valid = keep && pending_valid;
    push_data.a_char  = pending_char;
    push_data.a_next  = src.in_char;
    push_data.b_valid = src.in_last && (keep || pending_valid);
    push_data.b_char  = keep ? src.in_char : pending_char;
    push_data.last    = src.in_last;
    push_valid        = accept && (push_data.a_valid || src.in_last);
  end

  // Advance the held byte; return to the start state after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_char     <= CH_NUL;
      pending_valid    <= 1'b0;
      filter_in_quotes <= 1'b0;
    end else if (accept) begin
      if (src.in_last) begin
        pending_char     <= CH_NUL;
        pending_valid    <= 1'b0;
        filter_in_quotes <= 1'b0;
      end else begin
        filter_in_quotes <= quote_next;
        if (keep) begin
          pending_char  <= src.in_char;
          pending_valid <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/etl_fifo.sv @@
module etl_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  etl_pkg::job_t push_data,
  output logic          push_ready,
  input  logic          pop_ready,
  output logic          pop_valid,
  output etl_pkg::job_t pop_data
);
  import etl_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/etl_back.sv @@
module etl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  etl_pkg::job_t pop_data,
  output logic          pop_ready,
  etl_tok_if.source     tok
);
  import etl_pkg::*;

  typedef enum logic [2:0] {
    PH_A   = 3'b001,
    PH_B   = 3'b010,
    PH_END = 3'b100
  } phase_t;

  job_t    cur;
  logic    cur_valid;
  phase_t  phase;
  logic    idx;
  logic    skip_following;
  logic    lexer_in_quotes;
  result_t out_r;
  logic    out_valid;

  cls_t    cls;
  result_t res;
  logic    out_free;
  logic    step;
  logic    emit;
  logic    job_done;
  logic    has_next;
  phase_t  phase_next;
  phase_t  phase_first;
  logic    finish;
  logic    load;

  // Classify the job of the current phase
  always_comb begin
    out_free = !out_valid || tok.ready;
    step     = cur_valid && out_free;
    case (phase)
      PH_A:    cls = classify(cur.a_char, cur.a_next, skip_following, lexer_in_quotes);
      PH_B:    cls = classify(cur.b_char, CH_NUL, skip_following, lexer_in_quotes);
      PH_END: begin
        cls      = '0;
        cls.cnt  = 2'd1;
        cls.res0 = mk_empty(K_END);
      end
      default: cls = '0;
    endcase
    res      = idx ? cls.res1 : cls.res0;
    emit     = step && (cls.cnt > {1'b0, idx});
    job_done = (cls.cnt != 2'd2) || idx;
  end

  // Pick the phase that follows and the first phase of a new entry
  always_comb begin
    has_next   = 1'b0;
    phase_next = PH_END;
    case (phase)
      PH_A: begin
        if (cur.b_valid) begin
          has_next   = 1'b1;
          phase_next = PH_B;
        end else if (cur.last) begin
          has_next   = 1'b1;
          phase_next = PH_END;
        end
      end
      PH_B: begin
        has_next   = 1'b1;
        phase_next = PH_END;
      end
      default: has_next = 1'b0;
    endcase
    finish      = step && job_done && !has_next;
    load        = pop_valid && (!cur_valid || finish);
    phase_first = pop_data.a_valid ? PH_A : (pop_data.b_valid ? PH_B : PH_END);
  end

  assign pop_ready = load;

  // Sequence phases and hold the lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid       <= 1'b0;
      phase           <= PH_A;
      idx             <= 1'b0;
      skip_following  <= 1'b0;
      lexer_in_quotes <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= emit;
      end
      if (step) begin
        if (job_done) begin
          skip_following  <= cls.skip_n;
          lexer_in_quotes <= cls.inq_n;
          idx             <= 1'b0;
          if (has_next) begin
            phase <= phase_next;
          end
        end else begin
          idx <= 1'b1;
        end
      end
      if (load) begin
        cur_valid <= 1'b1;
        phase     <= phase_first;
        idx       <= 1'b0;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_data;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign tok.valid      = out_valid;
  assign tok.token_kind = out_r.kind;
  assign tok.text_char  = out_r.ch;
  assign tok.char_valid = out_r.cv;
  assign tok.token_end  = out_r.te;

endmodule

@@ rtl/expression_token_lexer_top.sv @@
// A byte's tokens leave after the transfer of the next kept byte (or of the final byte),
//   passing through the job queue, the sequencer and the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the receiver
//   is ready; the back end issues one result per cycle, and a skipped '=' yields no result.
// Reset: synchronous, active high; clears held byte, quote state, queue and output valid.
`include "expression_token_lexer_top_defines.svh"

module expression_token_lexer_top #(
  parameter int QueueDepth = 4
) (
  input  logic      clk,
  input  logic      rst,
  etl_src_if.sink   src,
  etl_tok_if.source tok
);
  import etl_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic pop_valid;
  logic pop_ready;
  job_t pop_data;

  etl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  etl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  etl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .tok       (tok)
  );

  // Checks
  `ETL_ASSERT_IMPLY(a_push_fits, push_valid, push_ready, "push into a full queue")
  `ETL_ASSERT_IMPLY(a_flush_on_last, push_valid && push_data.b_valid, push_data.last, "flush job without final byte")
  `ETL_ASSERT_IMPLY(a_empty_text, tok.valid && !tok.char_valid, tok.text_char == 8'h00 && tok.token_end, "empty token carries text")
  `ETL_ASSERT_IMPLY(a_end_token, tok.valid && tok.token_kind == K_END, !tok.char_valid && tok.token_end, "malformed END token")
  `ETL_ASSERT_ALWAYS(a_pop_has_data, !pop_ready || pop_valid, "pop from an empty queue")

endmodule

@@ tb/tb_expression_token_lexer_top.sv @@
module tb_expression_token_lexer_top;
  import etl_pkg::*;

  localparam int StallLimit = 3000;
  localparam int TailCycles = 20;
  localparam int PhaseBytes = 55;

  // One source byte with an optional hand-typed expectation (n_typed < 0: use the predictor)
  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         n_typed;
    result_t    t0;
    result_t    t1;
  } lex_row_t;

  logic clk;
  logic rst;

  etl_src_if src_ch ();
  etl_tok_if tok_ch ();

  expression_token_lexer_top i_dut (
    .clk (clk),
    .rst (rst),
    .src (src_ch),
    .tok (tok_ch)
  );

  // Lexer state mirrored by the predictor
  logic [7:0] held_char;
  logic       held_ok;
  logic       filt_quoted;
  logic       tok_quoted;
  logic       drop_eq;

  result_t  scratch_toks[$];
  result_t  token_backlog[$];
  lex_row_t plan[$];
  logic [7:0] text_buf[$];

  int err_count      = 0;
  int tokens_checked = 0;
  int bytes_sent     = 0;
  int texts_sent     = 0;
  int drain_pauses   = 0;
  int stall_cycles   = 0;
  int src_idle_pct   = 7;
  int snk_idle_pct   = 60;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t tok(kind_e k, logic [7:0] c, logic cv, logic te);
    result_t r;
    r.kind = k;
    r.ch   = cv ? c : CH_NUL;
    r.cv   = cv;
    r.te   = te;
    return r;
  endfunction

  function automatic logic is_alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void note_tok(kind_e k, logic [7:0] c, logic cv, logic te);
    scratch_toks.insert(scratch_toks.size(), tok(k, c, cv, te));
  endfunction

  // Classify the held byte against its lookahead
  function automatic void classify_held(logic [7:0] c, logic [7:0] nx);
    kind_e k;
    if (drop_eq) begin
      drop_eq = 1'b0;
      return;
    end
    if (c == CH_QUOTE) tok_quoted = !tok_quoted;
    if (tok_quoted) begin
      if (c == CH_QUOTE) begin
        note_tok(K_QUOTE, c, 1'b1, 1'b1);
        if (nx == CH_QUOTE) note_tok(K_STRING, CH_NUL, 1'b0, 1'b1);
      end else begin
        note_tok(K_STRING, c, 1'b1, nx == CH_QUOTE);
      end
      return;
    end
    if (is_alpha_ch(c)) begin
      note_tok(K_IDENT, c, 1'b1, !is_alpha_ch(nx));
      return;
    end
    if (is_num_ch(c)) begin
      note_tok(K_NUMBER, c, 1'b1, !is_num_ch(nx));
      return;
    end
    case (c)
      CH_PLUS:   note_tok(K_PLUS, c, 1'b1, 1'b1);
      CH_MINUS:  note_tok(K_MINUS, c, 1'b1, 1'b1);
      CH_STAR:   note_tok(K_MUL, c, 1'b1, 1'b1);
      CH_SLASH:  note_tok(K_DIV, c, 1'b1, 1'b1);
      CH_LPAREN: note_tok(K_LPAREN, c, 1'b1, 1'b1);
      CH_RPAREN: note_tok(K_RPAREN, c, 1'b1, 1'b1);
      CH_QUOTE:  note_tok(K_QUOTE, c, 1'b1, 1'b1);
      CH_LBRACE: note_tok(K_LBRACE, c, 1'b1, 1'b1);
      CH_RBRACE: note_tok(K_RBRACE, c, 1'b1, 1'b1);
      CH_LT, CH_GT, CH_BANG, CH_EQ: begin
        if (nx == CH_EQ) begin
          // merge with the following '=' and skip it
          k = (c == CH_LT) ? K_LE : (c == CH_GT) ? K_GE : (c == CH_BANG) ? K_NE : K_EQ;
          note_tok(k, c, 1'b1, 1'b0);
          note_tok(k, CH_EQ, 1'b1, 1'b1);
          drop_eq = 1'b1;
        end else begin
          k = (c == CH_LT) ? K_LT : (c == CH_GT) ? K_GT : (c == CH_BANG) ? K_OTHER : K_ASSIGN;
          note_tok(k, c, 1'b1, 1'b1);
        end
      end
      default:   note_tok(K_OTHER, CH_NUL, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void clear_lexer();
    held_char   = CH_NUL;
    held_ok     = 1'b0;
    filt_quoted = 1'b0;
    tok_quoted  = 1'b0;
    drop_eq     = 1'b0;
  endfunction

  // Predict the tokens released by one source byte into scratch_toks
  function automatic void lex_byte(logic [7:0] c, logic last);
    logic keep;
    scratch_toks.delete();
    if (c == CH_QUOTE) filt_quoted = !filt_quoted;
    keep = filt_quoted || (c != CH_SPACE && c != CH_NL);
    if (keep) begin
      if (held_ok) classify_held(held_char, c);
      held_char = c;
      held_ok   = 1'b1;
    end
    if (last) begin
      if (held_ok) classify_held(held_char, CH_NUL);
      note_tok(K_END, CH_NUL, 1'b0, 1'b1);
      clear_lexer();
    end
  endfunction

  function automatic void add_row(logic [7:0] ch, logic last = 1'b0, int n = -1,
                                  result_t t0 = '0, result_t t1 = '0);
    lex_row_t r;
    r.ch      = ch;
    r.last    = last;
    r.n_typed = n;
    r.t0      = t0;
    r.t1      = t1;
    plan.insert(plan.size(), r);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Drive one byte, hold it until its transfer, then queue its expected tokens
  task automatic push_byte(input lex_row_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      src_ch.valid <= 1'b0;
      @(posedge clk);
    end
    src_ch.valid   <= 1'b1;
    src_ch.in_char <= r.ch;
    src_ch.in_last <= r.last;
    do @(posedge clk); while (!src_ch.ready);
    bytes_sent++;
    lex_byte(r.ch, r.last);
    if (r.n_typed < 0) begin
      foreach (scratch_toks[i]) token_backlog.insert(token_backlog.size(), scratch_toks[i]);
    end else begin
      if (r.n_typed > 0) token_backlog.insert(token_backlog.size(), r.t0);
      if (r.n_typed > 1) token_backlog.insert(token_backlog.size(), r.t1);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h41, 8'h5A));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] pick_relop();
    case ($urandom_range(0, 3))
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_BANG;
      default: return CH_EQ;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 8))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_LPAREN;
      5:       return CH_RPAREN;
      6:       return CH_LBRACE;
      7:       return CH_RBRACE;
      default: return pick_relop();
    endcase
  endfunction

  // Build an expression text from random pieces, including random bytes and runs of '='
  task automatic build_text();
    int pieces;
    int n;
    text_buf.delete();
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 6);
          repeat (n) text_buf.insert(text_buf.size(), rand_letter());
        end
        2: begin
          n = $urandom_range(1, 5);
          repeat (n) text_buf.insert(text_buf.size(), 8'($urandom_range(8'h30, 8'h39)));
        end
        3: text_buf.insert(text_buf.size(), pick_op());
        4: begin
          text_buf.insert(text_buf.size(), pick_relop());
          text_buf.insert(text_buf.size(), CH_EQ);
        end
        5: begin
          n = $urandom_range(1, 2);
          repeat (n)
            text_buf.insert(text_buf.size(), ($urandom_range(0, 1) == 1) ? CH_SPACE : CH_NL);
        end
        6: begin
          // quoted text with printable content, spaces kept
          text_buf.insert(text_buf.size(), CH_QUOTE);
          n = $urandom_range(0, 4);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) text_buf.insert(text_buf.size(), CH_SPACE);
            else text_buf.insert(text_buf.size(), rand_letter());
          end
          text_buf.insert(text_buf.size(), CH_QUOTE);
        end
        7: text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
        8: begin
          text_buf.insert(text_buf.size(), CH_QUOTE);
          text_buf.insert(text_buf.size(), CH_QUOTE);
        end
        default: begin
          n = $urandom_range(2, 4);
          repeat (n) text_buf.insert(text_buf.size(), CH_EQ);
        end
      endcase
    end
  endtask

  // Send text_buf, last on the final byte and, if noisy, at random; returns non-blank count
  task automatic send_text(input logic noisy, output int counted);
    lex_row_t r;
    counted = 0;
    foreach (text_buf[i]) begin
      r.ch      = text_buf[i];
      r.last    = (i == text_buf.size() - 1) || (noisy && $urandom_range(0, 5) == 0);
      r.n_typed = -1;
      r.t0      = '0;
      r.t1      = '0;
      push_byte(r);
      if (r.ch != CH_SPACE && r.ch != CH_NL) counted++;
    end
    texts_sent++;
  endtask

  // Let the block drain everything predicted so far
  task automatic drain_tokens();
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (token_backlog.size() != 0) @(posedge clk);
    drain_pauses++;
  endtask

  // Check each token transfer and drive the receiver's stalls
  always @(posedge clk) begin
    result_t exp_tok;
    string   diff;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      tokens_checked++;
      if (token_backlog.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d char %02h cv %0b end %0b",
                                  tok_ch.token_kind, tok_ch.text_char, tok_ch.char_valid,
                                  tok_ch.token_end));
      end else begin
        exp_tok = token_backlog.pop_front();
        diff    = "";
        if (tok_ch.token_kind !== exp_tok.kind)
          diff = {diff, $sformatf(" kind %0d/%0d", tok_ch.token_kind, exp_tok.kind)};
        if (tok_ch.text_char !== exp_tok.ch)
          diff = {diff, $sformatf(" char %02h/%02h", tok_ch.text_char, exp_tok.ch)};
        if (tok_ch.char_valid !== exp_tok.cv)
          diff = {diff, $sformatf(" cv %0b/%0b", tok_ch.char_valid, exp_tok.cv)};
        if (tok_ch.token_end !== exp_tok.te)
          diff = {diff, $sformatf(" end %0b/%0b", tok_ch.token_end, exp_tok.te)};
        if (diff != "")
          report_mismatch($sformatf("token %0d (got/exp):%s", tokens_checked, diff));
      end
    end
    tok_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Stop the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (src_ch.valid && src_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Watchdog: no transfer for %0d cycles", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_bytes;
    int counted;
    logic noisy;
    clk            = 1'b0;
    rst            <= 1'b1;
    src_ch.valid   <= 1'b0;
    src_ch.in_char <= CH_NUL;
    src_ch.in_last <= 1'b0;
    clear_lexer();

    // Operators, runs, merged pairs, lone bang, non-ASCII and NUL bytes
    add_row(CH_NUL, 1'b0, 0);
    add_row(8'hFF, 1'b0, 1, tok(K_OTHER, CH_NUL, 1'b0, 1'b1));
    add_row("a", 1'b0, 1, tok(K_OTHER, CH_NUL, 1'b0, 1'b1));
    add_row("Z");
    add_row("9");
    add_row("0");
    add_row(CH_SPACE, 1'b0, 0);
    add_row(CH_PLUS);
    add_row(CH_MINUS);
    add_row(CH_STAR);
    add_row(CH_SLASH);
    add_row(CH_LBRACE);
    add_row(CH_RBRACE);
    add_row(CH_LT);
    add_row(CH_EQ);
    add_row(CH_GT);
    add_row(CH_BANG);
    add_row(CH_LPAREN, 1'b0, 1, tok(K_OTHER, CH_BANG, 1'b1, 1'b1));
    add_row(CH_RPAREN);
    add_row(CH_EQ);
    add_row(CH_EQ);
    add_row(CH_EQ);
    add_row(CH_BANG);
    add_row(CH_EQ, 1'b1);
    // Empty string, closing quote, then an unterminated string
    add_row(CH_QUOTE);
    add_row(CH_QUOTE, 1'b0, 2, tok(K_QUOTE, CH_QUOTE, 1'b1, 1'b1),
            tok(K_STRING, CH_NUL, 1'b0, 1'b1));
    add_row(CH_NL, 1'b0, 0);
    add_row(CH_QUOTE);
    add_row("a");
    add_row(CH_SPACE);
    add_row("x", 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) push_byte(plan[i]);
    texts_sent += 2;
    drain_tokens();

    // Random texts under three stall mixes
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 60 : 0;
      snk_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 7 : 0;
      phase_bytes  = 0;
      while (phase_bytes < PhaseBytes) begin
        noisy = ($urandom_range(0, 99) < 15);
        if (noisy) begin
          text_buf.delete();
          repeat ($urandom_range(1, 8))
            text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
        end else begin
          build_text();
        end
        send_text(noisy, counted);
        phase_bytes += counted;
      end
      drain_tokens();
    end

    repeat (TailCycles) @(posedge clk);
    if (token_backlog.size() != 0)
      report_mismatch($sformatf("%0d expected tokens never arrived", token_backlog.size()));

    $display("Run covered %0d source bytes in %0d texts, %0d tokens checked",
             bytes_sent, texts_sent, tokens_checked);
    $display("Stall mixes: slow receiver, slow sender, none; %0d drain pauses", drain_pauses);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
